// ===== design/srtf_preemptive_scheduler_macros.svh =====
// assertion macros for the srtf scheduler checkers
// needs nothing beyond the clock and reset names of the including module
`ifndef SRTF_PREEMPTIVE_SCHEDULER_MACROS_SVH
`define SRTF_PREEMPTIVE_SCHEDULER_MACROS_SVH

// generic form with explicit clock and active-low reset
`define SRTF_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// short form on clk_i and rst_ni
`define SRTF_ASSERT(label, prop, msg) `SRTF_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== design/srtf_pkg.sv =====
// shared constants and word layouts of the srtf scheduler
// used by the scheduler top level and its port checker, no dependencies
package srtf_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int TIME_BITS = 16;
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int SLOT_W    = 3;

  // command codes carried on tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 104;

  // input word, lowest field last in the list
  typedef struct packed {
    logic [4:0]  pad;
    logic [15:0] arrive_at;
    logic [15:0] burst_len;
    logic [2:0]  slot;
  } in_word_t;

  // result word, lowest field last in the list
  typedef struct packed {
    logic [1:0]  pad;
    logic        all_idle;
    logic [31:0] turnaround;
    logic [31:0] wait_ticks;
    logic        done_res;
    logic [2:0]  run_slot;
    logic        ran;
    logic [31:0] now;
  } out_word_t;

  // one job slot as held in the slot memory
  typedef struct packed {
    logic [TIME_BITS-1:0] arr;
    logic [TIME_BITS-1:0] burst;
    logic [TIME_BITS-1:0] rem;
  } slot_entry_t;

endpackage

// ===== design/srtf_preemptive_scheduler.sv =====
// shortest-remaining-time-first scheduler top level, all job slots in one synchronous memory
// depends on srtf_pkg
// a word is taken only in the idle state; a load word gives no result, while a tick word
//   runs the scan, select, wait and done states and then registers its result word
// ticks do not overlap: the scan reads one slot per cycle and the next word waits for idle
// reset: rst_ni async active low clears clock, running-job state, control and loaded flags
module srtf_preemptive_scheduler (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // slot[2:0], burst_len[18:3], arrive_at[34:19], zero fill
  input  logic [srtf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // cmd: 0 load a slot, 1 advance one tick
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // now[31:0], ran[32], run_slot[35:33], done_res[36], wait_ticks[68:37],
  // turnaround[100:69], all_idle[101], zero fill
  output logic [srtf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int IW = srtf_pkg::IDX_W;
  localparam int TW = srtf_pkg::TIME_BITS;
  localparam int NS = srtf_pkg::NUM_SLOTS;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_SEL  = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_q, state_d;

  srtf_pkg::in_word_t  in_word;
  srtf_pkg::out_word_t out_q, out_d;
  logic                out_vld_q, out_vld_d;

  assign in_word = srtf_pkg::in_word_t'(s_axis_tdata);

  // slot memory: one write port, one registered read port
  srtf_pkg::slot_entry_t mem_q [NS];
  srtf_pkg::slot_entry_t rdata_q;
  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  srtf_pkg::slot_entry_t mem_wdata;
  logic [IW-1:0]         mem_raddr;

  // loaded flags stand in for the all-zero reset of remaining time
  logic [NS-1:0] loaded_q, loaded_d;

  // scheduler state
  logic [31:0]   clock_q, clock_d;
  logic [IW-1:0] cur_job_q, cur_job_d;
  logic [TW-1:0] cur_rem_q, cur_rem_d;
  logic          has_cur_q, has_cur_d;

  // scan bookkeeping
  logic [IW:0]   iss_q, iss_d;
  logic          rd_vld_q, rd_vld_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic [TW-1:0] lim_q, lim_d;
  logic          lim_vld_q, lim_vld_d;
  logic          pick_vld_q, pick_vld_d;
  logic [IW-1:0] pick_idx_q, pick_idx_d;
  logic [IW:0]   nz_cnt_q, nz_cnt_d;
  srtf_pkg::slot_entry_t pick_ent_q, pick_ent_d;
  srtf_pkg::slot_entry_t cur_ent_q, cur_ent_d;

  // selection and finish stages
  logic          ran_q, ran_d;
  logic          done_q, done_d;
  logic          idle_q, idle_d;
  logic [IW-1:0] sel_idx_q, sel_idx_d;
  logic [TW-1:0] sel_burst_q, sel_burst_d;
  logic [TW:0]   sel_sum_q, sel_sum_d;
  logic [31:0]   wait_q, wait_d;

  // combinational helpers
  srtf_pkg::slot_entry_t rd_ent;
  logic                  rd_live;
  logic                  scan_elig;
  srtf_pkg::slot_entry_t sel_ent;
  logic                  sel_ran;
  logic [IW-1:0]         sel_idx;
  logic [TW-1:0]         new_rem;
  logic [32:0]           fin;
  logic [32:0]           sub;
  logic [32:0]           tat_sum;
  logic                  in_acc;
  logic                  slot_ok;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = srtf_pkg::OUT_TDATA_W'(out_q);

  // loads beyond the slot count are dropped
  assign slot_ok = (32'(in_word.slot) < 32'(NS));

  // an entry never loaded reads as zero remaining time
  always_comb begin
    rd_ent  = rdata_q;
    rd_live = loaded_q[rd_idx_q];
    if (!rd_live) begin
      rd_ent.rem = '0;
    end
  end

  // arrived, has work, and strictly below the current limit
  assign scan_elig = rd_vld_q && (32'(rd_ent.arr) <= clock_q) && (rd_ent.rem != '0) &&
                     (!lim_vld_q || (rd_ent.rem < lim_q));

  // final choice: best scanned slot, else keep the running job
  always_comb begin
    sel_ent = pick_ent_q;
    sel_idx = pick_idx_q;
    sel_ran = 1'b0;
    if (pick_vld_q) begin
      sel_ran = 1'b1;
    end else if (has_cur_q) begin
      sel_ent = cur_ent_q;
      sel_idx = cur_job_q;
      sel_ran = 1'b1;
    end
  end

  assign new_rem = sel_ent.rem - TW'(1);

  // finish tick is now + 1, compared against burst + arrival
  assign fin     = {1'b0, clock_q} + 33'd1;
  assign sub     = 33'(sel_sum_q);
  assign tat_sum = 33'(sel_burst_q) + 33'(wait_q);

  always_comb begin
    state_d     = state_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q;
    loaded_d    = loaded_q;
    clock_d     = clock_q;
    cur_job_d   = cur_job_q;
    cur_rem_d   = cur_rem_q;
    has_cur_d   = has_cur_q;
    iss_d       = iss_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    lim_d       = lim_q;
    lim_vld_d   = lim_vld_q;
    pick_vld_d  = pick_vld_q;
    pick_idx_d  = pick_idx_q;
    pick_ent_d  = pick_ent_q;
    cur_ent_d   = cur_ent_q;
    nz_cnt_d    = nz_cnt_q;
    ran_d       = ran_q;
    done_d      = done_q;
    idle_d      = idle_q;
    sel_idx_d   = sel_idx_q;
    sel_burst_d = sel_burst_q;
    sel_sum_d   = sel_sum_q;
    wait_d      = wait_q;
    mem_we      = 1'b0;
    mem_waddr   = IW'(in_word.slot);
    mem_wdata   = '{arr:   TW'(in_word.arrive_at),
                    burst: TW'(in_word.burst_len),
                    rem:   TW'(in_word.burst_len)};
    mem_raddr   = iss_q[IW-1:0];

    // result leaves the output register
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == srtf_pkg::CMD_LOAD) begin
            if (slot_ok) begin
              mem_we              = 1'b1;
              loaded_d[mem_waddr] = 1'b1;
              // reloading the running slot drops it back into competition
              if (has_cur_q && (cur_job_q == mem_waddr)) begin
                has_cur_d = 1'b0;
              end
            end
          end else begin
            state_d    = ST_SCAN;
            iss_d      = '0;
            lim_d      = cur_rem_q;
            lim_vld_d  = has_cur_q;
            pick_vld_d = 1'b0;
            nz_cnt_d   = '0;
          end
        end
      end
      ST_SCAN: begin
        // issue one read a cycle
        if (iss_q < (IW+1)'(NS)) begin
          rd_vld_d = 1'b1;
          rd_idx_d = iss_q[IW-1:0];
          iss_d    = iss_q + (IW+1)'(1);
        end
        // compare the entry read last cycle
        if (rd_vld_q) begin
          if (rd_ent.rem != '0) begin
            nz_cnt_d = nz_cnt_q + (IW+1)'(1);
          end
          if (rd_idx_q == cur_job_q) begin
            cur_ent_d = rd_ent;
          end
          if (scan_elig) begin
            lim_d      = rd_ent.rem;
            lim_vld_d  = 1'b1;
            pick_vld_d = 1'b1;
            pick_idx_d = rd_idx_q;
            pick_ent_d = rd_ent;
          end
        end else if (iss_q == (IW+1)'(NS)) begin
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        ran_d       = sel_ran;
        sel_idx_d   = sel_idx;
        done_d      = sel_ran && (new_rem == '0);
        sel_burst_d = sel_ent.burst;
        sel_sum_d   = (TW+1)'(sel_ent.burst) + (TW+1)'(sel_ent.arr);
        if (sel_ran) begin
          // write back one unit of work done
          mem_we    = 1'b1;
          mem_waddr = sel_idx;
          mem_wdata = '{arr: sel_ent.arr, burst: sel_ent.burst, rem: new_rem};
          if (new_rem == '0) begin
            has_cur_d = 1'b0;
            cur_rem_d = '0;
            idle_d    = (nz_cnt_q == (IW+1)'(1));
          end else begin
            has_cur_d = 1'b1;
            cur_job_d = sel_idx;
            cur_rem_d = new_rem;
            idle_d    = 1'b0;
          end
        end else begin
          has_cur_d = 1'b0;
          idle_d    = (nz_cnt_q == '0);
        end
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (done_q && (fin > sub)) begin
          wait_d = 32'(fin - sub);
        end else begin
          wait_d = '0;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_d.pad        = '0;
          out_d.now        = clock_q;
          out_d.ran        = ran_q;
          out_d.run_slot   = ran_q ? srtf_pkg::SLOT_W'(sel_idx_q) : '0;
          out_d.done_res   = done_q;
          out_d.wait_ticks = wait_q;
          out_d.all_idle   = idle_q;
          if (!done_q) begin
            out_d.turnaround = '0;
          end else if (tat_sum[32]) begin
            out_d.turnaround = '1;
          end else begin
            out_d.turnaround = tat_sum[31:0];
          end
          out_vld_d = 1'b1;
          clock_d   = clock_q + 32'd1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      loaded_q  <= '0;
      clock_q   <= '0;
      cur_job_q <= '0;
      cur_rem_q <= '0;
      has_cur_q <= 1'b0;
      iss_q     <= '0;
      rd_vld_q  <= 1'b0;
      lim_vld_q <= 1'b0;
      pick_vld_q <= 1'b0;
      nz_cnt_q  <= '0;
      ran_q     <= 1'b0;
      done_q    <= 1'b0;
      idle_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      loaded_q  <= loaded_d;
      clock_q   <= clock_d;
      cur_job_q <= cur_job_d;
      cur_rem_q <= cur_rem_d;
      has_cur_q <= has_cur_d;
      iss_q     <= iss_d;
      rd_vld_q  <= rd_vld_d;
      lim_vld_q <= lim_vld_d;
      pick_vld_q <= pick_vld_d;
      nz_cnt_q  <= nz_cnt_d;
      ran_q     <= ran_d;
      done_q    <= done_d;
      idle_q    <= idle_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q       <= out_d;
    rd_idx_q    <= rd_idx_d;
    lim_q       <= lim_d;
    pick_idx_q  <= pick_idx_d;
    pick_ent_q  <= pick_ent_d;
    cur_ent_q   <= cur_ent_d;
    sel_idx_q   <= sel_idx_d;
    sel_burst_q <= sel_burst_d;
    sel_sum_q   <= sel_sum_d;
    wait_q      <= wait_d;
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

endmodule

// ===== design/srtf_chk.sv =====
// port-level checker for the srtf scheduler, bound to the top level
// depends on srtf_pkg and srtf_preemptive_scheduler_macros.svh
`include "srtf_preemptive_scheduler_macros.svh"

module srtf_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [srtf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [srtf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  srtf_pkg::out_word_t ow;
  srtf_pkg::in_word_t  iw;

  assign ow = srtf_pkg::out_word_t'(m_axis_tdata);
  assign iw = srtf_pkg::in_word_t'(s_axis_tdata);

  // stalled word holds
  `SRTF_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

  // an idle tick reports nothing else
  `SRTF_ASSERT(a_idle_tick, m_axis_tvalid && !ow.ran |-> ow.run_slot == 3'd0 && !ow.done_res && ow.wait_ticks == 32'd0 && ow.turnaround == 32'd0, "idle tick with job fields set")

  // a finished job has turnaround at least its waiting time and nonzero
  `SRTF_ASSERT(a_tat_wait, m_axis_tvalid && ow.done_res |-> ow.ran && ow.turnaround >= ow.wait_ticks && ow.turnaround != 32'd0, "turnaround below waiting time")

  // all work gone after a running tick means that job finished
  `SRTF_ASSERT(a_idle_done, m_axis_tvalid && ow.ran && ow.all_idle |-> ow.done_res, "all idle while job still running")

endmodule

bind srtf_preemptive_scheduler srtf_chk u_srtf_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/srtf_preemptive_scheduler_checker.sv =====
`timescale 1ns / 100ps
// result checker for the srtf scheduler: watches both stream ports, predicts results
// depends on srtf_pkg for the word layouts and sizes
module srtf_preemptive_scheduler_checker
  import srtf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output int                     err_cnt_o,
  output int                     pending_o,
  output int                     results_o,
  output int                     finished_o,
  output int                     idle_ticks_o
);

  // scheduler state as this side sees it
  logic [TIME_BITS-1:0] rem_tab   [NUM_SLOTS];
  logic [TIME_BITS-1:0] burst_tab [NUM_SLOTS];
  logic [TIME_BITS-1:0] arr_tab   [NUM_SLOTS];
  logic [31:0]          tick_now;
  logic [IDX_W-1:0]     run_job;
  logic [TIME_BITS-1:0] run_rem;
  logic                 run_valid;

  out_word_t tick_results_q[$];

  task automatic field_check(input string name, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt_o++;
    end
  endtask

  // advance the schedule by one input word
  task automatic schedule_word(input logic cmd, input in_word_t w);
    logic [TIME_BITS:0] best;
    int                 pick;
    logic [32:0]        fin;
    logic [32:0]        sub;
    logic [33:0]        wt;
    logic [33:0]        tat;
    out_word_t          r;
    if (cmd == CMD_LOAD) begin
      if (w.slot < NUM_SLOTS) begin
        burst_tab[w.slot] = w.burst_len[TIME_BITS-1:0];
        arr_tab[w.slot]   = w.arrive_at[TIME_BITS-1:0];
        rem_tab[w.slot]   = w.burst_len[TIME_BITS-1:0];
        // reloading the running slot drops it back into the pool
        if (run_valid && run_job == w.slot[IDX_W-1:0])
          run_valid = 1'b0;
      end
    end else begin
      // the running job is displaced only by a strictly shorter one
      best = run_valid ? {1'b0, run_rem} : '1;
      pick = -1;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        if (32'(arr_tab[j]) <= tick_now && rem_tab[j] != '0 && {1'b0, rem_tab[j]} < best) begin
          best = {1'b0, rem_tab[j]};
          pick = j;
        end
      end
      if (pick < 0 && run_valid)
        pick = int'(run_job);
      r = '0;
      r.now = tick_now;
      if (pick >= 0) begin
        if (rem_tab[pick] != '0)
          rem_tab[pick] = rem_tab[pick] - 1'b1;
        r.ran      = 1'b1;
        r.run_slot = 3'(pick);
        if (rem_tab[pick] == '0) begin
          fin = {1'b0, tick_now} + 33'd1;
          sub = 33'(burst_tab[pick]) + 33'(arr_tab[pick]);
          // waiting time clamps at zero and saturates like turnaround
          wt  = (fin > sub) ? 34'(fin - sub) : '0;
          if (wt > 34'hFFFF_FFFF)
            wt = 34'hFFFF_FFFF;
          tat = 34'(burst_tab[pick]) + wt;
          if (tat > 34'hFFFF_FFFF)
            tat = 34'hFFFF_FFFF;
          r.done_res   = 1'b1;
          r.wait_ticks = wt[31:0];
          r.turnaround = tat[31:0];
          run_valid    = 1'b0;
          run_rem      = '0;
        end else begin
          run_valid = 1'b1;
          run_job   = IDX_W'(pick);
          run_rem   = rem_tab[pick];
        end
      end else begin
        run_valid = 1'b0;
      end
      tick_now   = tick_now + 32'd1;
      r.all_idle = 1'b1;
      for (int j = 0; j < NUM_SLOTS; j++)
        if (rem_tab[j] != '0)
          r.all_idle = 1'b0;
      tick_results_q.push_back(r);
    end
  endtask

  always @(posedge clk_i) begin
    out_word_t exp_w;
    out_word_t act_w;
    if (!rst_ni) begin
      for (int j = 0; j < NUM_SLOTS; j++) begin
        rem_tab[j]   = '0;
        burst_tab[j] = '0;
        arr_tab[j]   = '0;
      end
      tick_now  = '0;
      run_job   = '0;
      run_rem   = '0;
      run_valid = 1'b0;
      tick_results_q.delete();
    end else begin
      // result side first: a word accepted here was predicted earlier
      if (m_axis_tvalid && m_axis_tready) begin
        act_w = out_word_t'(m_axis_tdata);
        if (tick_results_q.size() == 0) begin
          $error("result word with no tick waiting: now %0d", act_w.now);
          err_cnt_o++;
        end else begin
          exp_w = tick_results_q.pop_front();
          field_check("now", exp_w.now, act_w.now);
          field_check("ran", exp_w.ran, act_w.ran);
          field_check("run_slot", exp_w.run_slot, act_w.run_slot);
          field_check("done_res", exp_w.done_res, act_w.done_res);
          field_check("wait_ticks", exp_w.wait_ticks, act_w.wait_ticks);
          field_check("turnaround", exp_w.turnaround, act_w.turnaround);
          field_check("all_idle", exp_w.all_idle, act_w.all_idle);
          if (exp_w.done_res)
            finished_o++;
          if (!exp_w.ran)
            idle_ticks_o++;
        end
        results_o++;
      end
      if (s_axis_tvalid && s_axis_tready)
        schedule_word(s_axis_tuser, in_word_t'(s_axis_tdata));
    end
    pending_o = tick_results_q.size();
  end

  initial begin
    err_cnt_o    = 0;
    pending_o    = 0;
    results_o    = 0;
    finished_o   = 0;
    idle_ticks_o = 0;
  end

endmodule

// ===== verif/srtf_preemptive_scheduler_test.sv =====
`timescale 1ns / 100ps
// top of the srtf scheduler regression: clock, reset, load and tick stimulus, verdict
// depends on srtf_pkg, the scheduler rtl and srtf_preemptive_scheduler_checker
module srtf_preemptive_scheduler_test;
  import srtf_pkg::*;

  localparam int RANDOM_WORDS = 1500;
  localparam int LONG_HOLD    = 400;   // receiver stall that fills the block up
  localparam int STALL_LIMIT  = 5000;  // cycles with no word moving on either port
  localparam int DRAIN_CYCLES = 40;    // idle time after the last result before the verdict

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // slot, burst_len, arrive_at, zero fill
  logic                   s_axis_tuser = 1'b0; // cmd
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // now, ran, run_slot, done_res, wait_ticks,
                                               // turnaround, all_idle, zero fill

  int err_cnt, pending, results, finished, idle_ticks;
  int loads_sent, ticks_sent, words_sent;
  int hold_req_num;  // bumped by the sender to ask the receiver for one long stall
  bit tx_steady;
  int stall_cycles;

  always #5 clk_i = ~clk_i;

  srtf_preemptive_scheduler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  srtf_preemptive_scheduler_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .err_cnt_o     (err_cnt),
    .pending_o     (pending),
    .results_o     (results),
    .finished_o    (finished),
    .idle_ticks_o  (idle_ticks)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one word at the falling edge and hold it until the block takes it
  task automatic send_word(input logic cmd, input logic [2:0] slot,
                           input logic [15:0] burst, input logic [15:0] arr);
    in_word_t w;
    int       g;
    w           = '0;
    w.slot      = slot;
    w.burst_len = burst;
    w.arrive_at = arr;
    g = tx_steady ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(w);
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    if (cmd == CMD_TICK)
      ticks_sent++;
    else
      loads_sent++;
    words_sent++;
    if (words_sent % 40 == 0)
      tx_steady = ($urandom_range(0, 3) == 0);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // job lengths: mostly short so jobs finish, with zero and very long ones mixed in
  function automatic logic [15:0] pick_burst();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 16'd0;
    if (r < 12) return 16'($urandom);
    if (r < 14) return 16'hFFFF;
    return 16'($urandom_range(1, 12));
  endfunction

  // arrivals mostly near the current tick, a few anywhere in the 16-bit range
  function automatic logic [15:0] pick_arrival();
    int base;
    if ($urandom_range(0, 9) == 0)
      return 16'($urandom);
    base = (ticks_sent > 4) ? ticks_sent - 4 : 0;
    return 16'(base + $urandom_range(0, 12));
  endfunction

  // receiver: random stalls, steady stretches, and one long hold on request
  initial begin
    int rx_wait;
    int holds_done;
    int cyc;
    bit rx_steady;
    rx_wait    = 0;
    holds_done = 0;
    cyc        = 0;
    rx_steady  = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 200 == 0)
        rx_steady = ($urandom_range(0, 2) == 0);
      if (hold_req_num != holds_done) begin
        holds_done++;
        rx_wait = LONG_HOLD;
      end
      if (rx_wait > 0) begin
        m_axis_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0)
          rx_wait = gap_len();
      end
    end
  end

  // watchdog: nothing moving for too long means the block hung
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles == STALL_LIMIT) begin
      $display("srtf_preemptive_scheduler regression: fail");
      $finish;
    end
  end

  initial begin
    int n_jobs;
    int n_steps;
    bit hold_done;
    bit pause_done;
    hold_req_num = 0;
    stall_cycles = 0;
    loads_sent   = 0;
    ticks_sent   = 0;
    words_sent   = 0;
    tx_steady    = 1'b0;
    hold_done    = 1'b0;
    pause_done   = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: idle tick, ties, preemption, reload of the running slot,
    // zero burst, never-arriving and longest jobs, back to all idle
    send_word(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_word(CMD_LOAD, 3'd1, 16'd2, 16'd0);
    send_word(CMD_LOAD, 3'd2, 16'd2, 16'd0);         // ties with slot 1, lower slot wins
    send_word(CMD_LOAD, 3'd6, 16'hFFFF, 16'hFFFF);   // arrives far beyond this run
    send_word(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_word(CMD_LOAD, 3'd4, 16'd1, 16'd2);         // equal to running job, no preemption
    send_word(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_word(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_word(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_word(CMD_LOAD, 3'd2, 16'd3, 16'd0);         // reload the slot that is running
    send_word(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_word(CMD_LOAD, 3'd7, 16'd1, 16'd0);         // strictly shorter, preempts
    send_word(CMD_LOAD, 3'd0, 16'd0, 16'd0);         // zero burst holds no work
    send_word(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_word(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_word(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_word(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_word(CMD_LOAD, 3'd6, 16'd0, 16'd0);         // drop the far job
    send_word(CMD_LOAD, 3'd5, 16'hFFFF, 16'd0);      // longest burst, arrived at once
    send_word(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_word(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_word(CMD_LOAD, 3'd5, 16'd0, 16'hFFFF);
    send_word(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_word(CMD_TICK, 3'd0, 16'd0, 16'd0);
    wait_results_drained();

    // random: batches of jobs, run them with the odd late load, sometimes clear all slots
    while (words_sent < RANDOM_WORDS + 24) begin
      n_jobs = $urandom_range(1, 6);
      repeat (n_jobs)
        send_word(CMD_LOAD, 3'($urandom_range(0, 7)), pick_burst(), pick_arrival());
      n_steps = $urandom_range(4, 40);
      repeat (n_steps) begin
        if ($urandom_range(0, 9) == 0)
          send_word(CMD_LOAD, 3'($urandom_range(0, 7)), pick_burst(), pick_arrival());
        else
          send_word(CMD_TICK, 3'($urandom), 16'($urandom), 16'($urandom));
      end
      if ($urandom_range(0, 3) == 0) begin
        for (int s = 0; s < NUM_SLOTS; s++)
          send_word(CMD_LOAD, 3'(s), 16'd0, 16'($urandom));
      end
      // long receiver hold while ticks keep coming, so the block backs up
      if (!hold_done && words_sent > 500) begin
        hold_done = 1'b1;
        hold_req_num++;
        repeat (60)
          send_word(CMD_TICK, 3'd0, 16'd0, 16'd0);
      end
      // sender pause until every pending result is out
      if (!pause_done && words_sent > 1000) begin
        pause_done = 1'b1;
        wait_results_drained();
      end
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("covered %0d loads and %0d ticks: %0d results checked, %0d jobs finished,",
             loads_sent, ticks_sent, results, finished);
    $display("%0d idle ticks, one long receiver hold and one drain pause", idle_ticks);
    if (err_cnt == 0 && pending == 0)
      $display("srtf_preemptive_scheduler regression: pass");
    else
      $display("srtf_preemptive_scheduler regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/srtf_pkg.sv
design/srtf_preemptive_scheduler.sv
design/srtf_chk.sv
verif/srtf_preemptive_scheduler_checker.sv
verif/srtf_preemptive_scheduler_test.sv
